@@ sv/smpu_pkg.sv @@
`timescale 1ns / 1ps
package smpu_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int CELL_BITS = 32;
	localparam int ADDR_BITS = $clog2(STACK_DEPTH);
	localparam int DEPTH_BITS = $clog2(STACK_DEPTH + 1);
	localparam int DIV_CNT_BITS = $clog2(CELL_BITS + 1);

	typedef logic [CELL_BITS-1:0] cell_t;
	typedef logic [DEPTH_BITS-1:0] depth_t;
	typedef logic [ADDR_BITS-1:0] addr_t;

	localparam logic [4:0] OP_PUSH = 5'd0;
	localparam logic [4:0] OP_DOT = 5'd1;
	localparam logic [4:0] OP_CR = 5'd2;
	localparam logic [4:0] OP_DUP = 5'd3;
	localparam logic [4:0] OP_SWAP = 5'd4;
	localparam logic [4:0] OP_OVER = 5'd5;
	localparam logic [4:0] OP_ROT = 5'd6;
	localparam logic [4:0] OP_EMIT = 5'd7;
	localparam logic [4:0] OP_MOD = 5'd8;
	localparam logic [4:0] OP_AND = 5'd9;
	localparam logic [4:0] OP_OR = 5'd10;
	localparam logic [4:0] OP_INVERT = 5'd11;
	localparam logic [4:0] OP_DROP = 5'd12;
	localparam logic [4:0] OP_ADD = 5'd13;
	localparam logic [4:0] OP_SUB = 5'd14;
	localparam logic [4:0] OP_MUL = 5'd15;
	localparam logic [4:0] OP_DIV = 5'd16;
	localparam logic [4:0] OP_EQ = 5'd17;
	localparam logic [4:0] OP_LT = 5'd18;
	localparam logic [4:0] OP_GT = 5'd19;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_NUM = 2'd1;
	localparam logic [1:0] KIND_CHAR = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER = 2'd2;
	localparam logic [1:0] ST_DIVZ = 2'd3;

	localparam logic [31:0] NEWLINE = 32'd10;

	typedef struct packed {
		logic [4:0] opcode;
		logic signed [31:0] literal;
	} req_t;

	typedef struct packed {
		logic [1:0] print_kind;
		logic signed [31:0] print_value;
		logic [1:0] status;
		logic [6:0] stack_depth_out;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RD0, S_RD1, S_RD2, S_EXEC, S_DIV, S_WB
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic rd_a;
		logic rd_b;
		logic rd_c;
		logic exec;
		logic div_start;
		logic writeback;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} sts_t;

	function automatic logic [1:0] need_of(input logic [4:0] op);
		case (op) inside
			OP_DOT, OP_DUP, OP_EMIT, OP_INVERT, OP_DROP: need_of = 2'd1;
			OP_SWAP, OP_OVER, OP_MOD, OP_AND, OP_OR, [OP_ADD:OP_GT]: need_of = 2'd2;
			OP_ROT: need_of = 2'd3;
			default: need_of = 2'd0;
		endcase
	endfunction

	function automatic logic grow_of(input logic [4:0] op);
		grow_of = (op == OP_PUSH) || (op == OP_DUP) || (op == OP_OVER);
	endfunction

endpackage

@@ sv/smpu_divider.sv @@
`timescale 1ns / 1ps
module smpu_divider import smpu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  cell_t dividend,
	input  cell_t divisor,
	output logic  done,
	output cell_t quot,
	output cell_t rem
);
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic running_q;
	cell_t dvs_q, quo_q;
	logic [CELL_BITS:0] rem_q;
	logic neg_q_q, neg_r_q;
	cell_t ma, mb;
	logic [CELL_BITS:0] trial;

	assign mb = dividend[CELL_BITS-1] ? cell_t'(-dividend) : dividend;
	assign ma = divisor[CELL_BITS-1] ? cell_t'(-divisor) : divisor;
	assign trial = {rem_q[CELL_BITS-1:0], quo_q[CELL_BITS-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			running_q <= 1'b1;
			cnt_q <= DIV_CNT_BITS'(CELL_BITS);
		end else if (running_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_BITS'(1)) running_q <= 1'b0;
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mb;
			dvs_q <= ma;
			rem_q <= '0;
			neg_q_q <= dividend[CELL_BITS-1] ^ divisor[CELL_BITS-1];
			neg_r_q <= dividend[CELL_BITS-1];
		end else if (running_q) begin
			if (!trial[CELL_BITS]) begin
				rem_q <= trial;
				quo_q <= {quo_q[CELL_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CELL_BITS-1:0], quo_q[CELL_BITS-1]};
				quo_q <= {quo_q[CELL_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = running_q && (cnt_q == DIV_CNT_BITS'(1));
	assign quot = neg_q_q ? cell_t'(-quo_q) : quo_q;
	assign rem = neg_r_q ? cell_t'(-rem_q[CELL_BITS-1:0]) : rem_q[CELL_BITS-1:0];
endmodule

@@ sv/smpu_datapath.sv @@
`timescale 1ns / 1ps
module smpu_datapath import smpu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output res_t res
);
	cell_t mem [STACK_DEPTH];
	cell_t rdata_q, a_q, b_q, c_q, bin_res, pval;
	logic [4:0] op_q;
	cell_t lit_q;
	depth_t depth_q;
	logic [1:0] stat_q, pkind, stat_d;
	logic [1:0] wcnt_q;
	logic [CELL_BITS-1:0] prod_q;
	logic div_done;
	cell_t quot, rem;
	addr_t raddr;
	logic [1:0] need;

	assign need = need_of(op_q);

	// the cycle after rd_x the read data lands in rdata_q
	always_comb begin
		raddr = addr_t'(depth_q - 1'b1);
		if (cmd.rd_b) raddr = addr_t'(depth_q - 2'd2);
		if (cmd.rd_c) raddr = addr_t'(depth_q - 2'd3);
	end

	logic rd_a_q, rd_b_q, rd_c_q;
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		rd_a_q <= cmd.rd_a;
		rd_b_q <= cmd.rd_b;
		rd_c_q <= cmd.rd_c;
		if (rd_a_q) a_q <= rdata_q;
		if (rd_b_q) b_q <= rdata_q;
		if (rd_c_q) c_q <= rdata_q;
	end

	smpu_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(b_q), .divisor(a_q), .done(div_done), .quot(quot), .rem(rem)
	);

	// fault check, valid in the exec cycle
	always_comb begin
		if (depth_q < depth_t'(need)) stat_d = ST_UNDER;
		else if (grow_of(op_q) && depth_q >= depth_t'(STACK_DEPTH)) stat_d = ST_OVER;
		else if ((op_q == OP_DIV || op_q == OP_MOD) && a_q == '0) stat_d = ST_DIVZ;
		else stat_d = ST_OK;
	end

	assign sts.need_div = (stat_d == ST_OK) && ((op_q == OP_DIV) || (op_q == OP_MOD));
	assign sts.div_done = div_done;

	// depth moves once, in the first writeback cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) depth_q <= '0;
		else if (cmd.writeback && stat_q == ST_OK && wcnt_q == 2'd0) begin
			case (op_q) inside
				OP_PUSH, OP_DUP, OP_OVER: depth_q <= depth_q + 1'b1;
				OP_DOT, OP_EMIT, OP_DROP, OP_MOD, OP_AND, OP_OR,
				[OP_ADD:OP_GT]: depth_q <= depth_q - 1'b1;
				default: depth_q <= depth_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req.opcode;
			lit_q <= cell_t'(req.literal);
		end
		if (cmd.exec) begin
			prod_q <= b_q * a_q;
			stat_q <= stat_d;
		end
	end

	// result for binary ops, settled by the first writeback cycle
	always_comb begin
		case (op_q)
			OP_MOD: bin_res = rem;
			OP_DIV: bin_res = quot;
			OP_AND: bin_res = b_q & a_q;
			OP_OR: bin_res = b_q | a_q;
			OP_ADD: bin_res = b_q + a_q;
			OP_SUB: bin_res = b_q - a_q;
			OP_MUL: bin_res = prod_q;
			OP_EQ: bin_res = (b_q == a_q) ? '1 : '0;
			OP_LT: bin_res = ($signed(b_q) < $signed(a_q)) ? '1 : '0;
			OP_GT: bin_res = ($signed(a_q) < $signed(b_q)) ? '1 : '0;
			default: bin_res = '0;
		endcase
	end

	// wcnt_q counts the writeback cycles, at most one write a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wcnt_q <= '0;
		else if (cmd.writeback) wcnt_q <= wcnt_q + 1'b1;
		else wcnt_q <= '0;
	end

	logic we;
	addr_t waddr;
	cell_t wdata;
	always_comb begin
		we = 1'b0;
		waddr = addr_t'(depth_q);
		wdata = a_q;
		if (cmd.writeback && stat_q == ST_OK && wcnt_q == 2'd0) begin
			case (op_q) inside
				OP_PUSH: begin we = 1'b1; wdata = lit_q; end
				OP_DUP: we = 1'b1;
				OP_OVER: begin we = 1'b1; wdata = b_q; end
				OP_SWAP, OP_ROT: begin
					we = 1'b1; waddr = addr_t'(depth_q - 1'b1);
					wdata = (op_q == OP_SWAP) ? b_q : c_q;
				end
				OP_INVERT: begin we = 1'b1; waddr = addr_t'(depth_q - 1'b1); wdata = ~a_q; end
				OP_MOD, OP_AND, OP_OR, [OP_ADD:OP_GT]: begin
					we = 1'b1; waddr = addr_t'(depth_q - 2'd2); wdata = bin_res;
				end
				default: we = 1'b0;
			endcase
		end
	end

	// the remaining swap/rot writes follow the first one: one more for swap, two for rot
	logic we2;
	addr_t waddr2;
	cell_t wdata2;
	always_comb begin
		we2 = 1'b0;
		waddr2 = addr_t'(depth_q - 2'd2);
		wdata2 = a_q;
		if (cmd.writeback && stat_q == ST_OK && wcnt_q == 2'd1
			&& (op_q == OP_SWAP || op_q == OP_ROT)) we2 = 1'b1;
		if (cmd.writeback && stat_q == ST_OK && wcnt_q == 2'd2 && op_q == OP_ROT) begin
			we2 = 1'b1; waddr2 = addr_t'(depth_q - 2'd3); wdata2 = b_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		else if (we2) mem[waddr2] <= wdata2;
	end

	always_comb begin
		pkind = KIND_NONE;
		pval = '0;
		if (stat_q == ST_OK) begin
			case (op_q)
				OP_DOT: begin pkind = KIND_NUM; pval = a_q; end
				OP_EMIT: begin pkind = KIND_CHAR; pval = a_q; end
				OP_CR: begin pkind = KIND_CHAR; pval = NEWLINE; end
				default: pkind = KIND_NONE;
			endcase
		end
	end

	assign res.print_kind = pkind;
	assign res.print_value = pval;
	assign res.status = stat_q;
	assign res.stack_depth_out = 7'(depth_q);
endmodule

@@ sv/smpu_ctrl.sv @@
`timescale 1ns / 1ps
module smpu_ctrl import smpu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);
	state_t state_q, state_d;
	logic [1:0] wb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wb_q <= '0;
		end else begin
			state_q <= state_d;
			wb_q <= (state_q == S_WB) ? wb_q + 1'b1 : 2'd0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_RD0;
			S_RD0: state_d = S_RD1;
			S_RD1: state_d = S_RD2;
			S_RD2: state_d = S_EXEC;
			S_EXEC: state_d = sts.need_div ? S_DIV : S_WB;
			S_DIV: if (sts.div_done) state_d = S_WB;
			S_WB: if (wb_q == 2'd2) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != S_IDLE);
		done = 1'b0;
		case (state_q)
			S_IDLE: cmd.load = start;
			S_RD0: cmd.rd_a = 1'b1;
			S_RD1: cmd.rd_b = 1'b1;
			S_RD2: cmd.rd_c = 1'b1;
			S_EXEC: begin cmd.exec = 1'b1; cmd.div_start = 1'b1; end
			S_DIV: cmd.div_start = 1'b0;
			S_WB: begin cmd.writeback = 1'b1; done = (wb_q == 2'd2); end
			default: cmd = '0;
		endcase
	end
endmodule

@@ sv/stack_machine_primitive_unit.sv @@
`timescale 1ns / 1ps
// forth data-stack primitive unit
// request: drive req (opcode, literal) and raise start while busy is low;
// the request is taken at that edge and busy rises the next cycle.
// result: rsp is valid for exactly one cycle, marked by done; the receiver
// cannot stall, so it must take it in that cycle.
// sequence: three stack reads, the check, then writeback; div and mod wait
// between the check and writeback for the one-bit-per-cycle restoring
// divider. one request at a time: the next is taken once busy falls after done.
// errors (underflow, overflow, zero divisor) report status, stack unchanged.
// reset clears the stack depth and the controller; cell memory is not
// cleared; only cells below the depth are used, and those are written first.
// opcodes above 19 do nothing and report ok.
module stack_machine_primitive_unit import smpu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output res_t rsp
);
	cmd_t cmd;
	sts_t sts;

	smpu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done)
	);

	smpu_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts), .res(rsp)
	);
endmodule
